[src/gsmv_pkg.sv]
// ----------------------------------------------------------------------------
// gsmv_pkg: shared definitions for the group scaled int8 matvec block
// Register codes, field widths, defaults and controller/datapath link types.
// ----------------------------------------------------------------------------
package gsmv_pkg;

    // Defaults for the top level parameters.
    localparam int MAX_GROUP_SIZE_DEF      = 256;
    localparam int SCALE_FRACTION_BITS_DEF = 28;

    // Configuration register widths and port widths.
    localparam int GS_CFG_W   = 9;
    localparam int GPR_CFG_W  = 13;
    localparam int RC_CFG_W   = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUPS_PER_ROW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT      = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [GS_CFG_W-1:0]  GS_RESET  = 9'd32;
    localparam logic [GPR_CFG_W-1:0] GPR_RESET = 13'd8;
    localparam logic [RC_CFG_W-1:0]  RC_RESET  = 17'd288;

    // Upper limits of the effective row geometry.
    localparam logic [GPR_CFG_W-1:0] GPR_MAX = 13'd4096;
    localparam logic [RC_CFG_W-1:0]  RC_MAX  = 17'd65536;

    // Payload widths.
    localparam int ELEM_W  = 8;
    localparam int SCALE_W = 32;
    localparam int ROW_W   = 48;

    // Cycles the scale pipeline needs from the group end to a valid term.
    localparam int SCALE_CYCLES = 5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // an item is taken this cycle
        logic grp_end;   // the taken item closes a group
        logic commit;    // fold the finished term into the row sum
        logic row_end;   // the committed term closes a row
        logic last;      // the closed row is the last row of the matrix
    } gsmv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // the output register can take a row this cycle
    } gsmv_stat_t;

endpackage

[src/gsmv_ctrl.sv]
// ----------------------------------------------------------------------------
// gsmv_ctrl: controller of the group scaled int8 matvec block
// Holds the configuration, the element, group and row counters and the
// state machine that sequences accumulation, scaling and row commit.
// ----------------------------------------------------------------------------
module gsmv_ctrl #(
    parameter int MAX_GROUP_SIZE = gsmv_pkg::MAX_GROUP_SIZE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           cfg_we,
    input  logic [gsmv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsmv_pkg::CFG_DATA_W-1:0] cfg_data,
    input  gsmv_pkg::gsmv_stat_t           stat,
    output gsmv_pkg::gsmv_cmd_t            cmd
);
    import gsmv_pkg::*;

    localparam int IDX_W = (MAX_GROUP_SIZE > 1) ? $clog2(MAX_GROUP_SIZE) : 1;
    localparam int GS_W  = (IDX_W + 1 > GS_CFG_W) ? IDX_W + 1 : GS_CFG_W;
    localparam logic [GS_W-1:0] GS_MAX = GS_W'(MAX_GROUP_SIZE);

    localparam logic [1:0] ST_ACC    = 2'd0;
    localparam logic [1:0] ST_SCALE  = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [GS_CFG_W-1:0]  gs_cfg_reg;
    logic [GPR_CFG_W-1:0] gpr_cfg_reg;
    logic [RC_CFG_W-1:0]  rc_cfg_reg;

    logic [1:0]           state_reg, state_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [IDX_W-1:0]     elem_reg, elem_next;
    logic [GPR_CFG_W-2:0] grp_reg, grp_next;
    logic [RC_CFG_W-2:0]  row_reg, row_next;
    logic                 row_end_reg, row_end_next;
    logic                 last_reg, last_next;

    logic [GS_W-1:0]      gs_eff;
    logic [GPR_CFG_W-1:0] gpr_eff;
    logic [RC_CFG_W-1:0]  rc_eff;
    logic                 accept, grp_end, row_end, last, commit;

    // Zero acts as one; values above the limits are held at the limits.
    always_comb begin
        if (gs_cfg_reg == '0) begin
            gs_eff = GS_W'(1);
        end else if (GS_W'(gs_cfg_reg) > GS_MAX) begin
            gs_eff = GS_MAX;
        end else begin
            gs_eff = GS_W'(gs_cfg_reg);
        end
        if (gpr_cfg_reg == '0) begin
            gpr_eff = GPR_CFG_W'(1);
        end else if (gpr_cfg_reg > GPR_MAX) begin
            gpr_eff = GPR_MAX;
        end else begin
            gpr_eff = gpr_cfg_reg;
        end
        if (rc_cfg_reg == '0) begin
            rc_eff = RC_CFG_W'(1);
        end else if (rc_cfg_reg > RC_MAX) begin
            rc_eff = RC_MAX;
        end else begin
            rc_eff = rc_cfg_reg;
        end
    end

    assign s_ready = (state_reg == ST_ACC);
    assign accept  = s_valid && s_ready;
    assign grp_end = (GS_W'(elem_reg) + GS_W'(1)) >= gs_eff;
    assign row_end = ({1'b0, grp_reg} + GPR_CFG_W'(1)) >= gpr_eff;
    assign last    = ({1'b0, row_reg} + RC_CFG_W'(1)) >= rc_eff;
    assign commit  = (state_reg == ST_COMMIT) && (!row_end_reg || stat.out_free);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        elem_next    = elem_reg;
        grp_next     = grp_reg;
        row_next     = row_reg;
        row_end_next = row_end_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_ACC: begin
                if (accept) begin
                    if (grp_end) begin
                        elem_next    = '0;
                        row_end_next = row_end;
                        last_next    = last;
                        state_next   = ST_SCALE;
                        cnt_next     = '0;
                        if (row_end) begin
                            grp_next = '0;
                            row_next = last ? '0 : row_reg + 1'b1;
                        end else begin
                            grp_next = grp_reg + 1'b1;
                        end
                    end else begin
                        elem_next = elem_reg + 1'b1;
                    end
                end
            end
            ST_SCALE: begin
                if (cnt_reg == 3'(SCALE_CYCLES - 1)) begin
                    state_next = ST_COMMIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                if (commit) begin
                    state_next = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gs_cfg_reg  <= GS_RESET;
            gpr_cfg_reg <= GPR_RESET;
            rc_cfg_reg  <= RC_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GROUP_SIZE:     gs_cfg_reg  <= cfg_data[GS_CFG_W-1:0];
                REG_GROUPS_PER_ROW: gpr_cfg_reg <= cfg_data[GPR_CFG_W-1:0];
                REG_ROW_COUNT:      rc_cfg_reg  <= cfg_data[RC_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            cnt_reg     <= '0;
            elem_reg    <= '0;
            grp_reg     <= '0;
            row_reg     <= '0;
            row_end_reg <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            elem_reg    <= elem_next;
            grp_reg     <= grp_next;
            row_reg     <= row_next;
            row_end_reg <= row_end_next;
            last_reg    <= last_next;
        end
    end

    assign cmd.accept  = accept;
    assign cmd.grp_end = grp_end;
    assign cmd.commit  = commit;
    assign cmd.row_end = row_end_reg;
    assign cmd.last    = last_reg;

endmodule

[src/gsmv_datapath.sv]
// ----------------------------------------------------------------------------
// gsmv_datapath: arithmetic of the group scaled int8 matvec block
// Multiply-accumulate of element pairs, the scale pipeline that turns a group
// sum into a Q.24 term, the saturating row sum and the output register.
// ----------------------------------------------------------------------------
module gsmv_datapath #(
    parameter int MAX_GROUP_SIZE      = gsmv_pkg::MAX_GROUP_SIZE_DEF,
    parameter int SCALE_FRACTION_BITS = gsmv_pkg::SCALE_FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  gsmv_pkg::gsmv_cmd_t                 cmd,
    output gsmv_pkg::gsmv_stat_t                stat,
    input  logic signed [gsmv_pkg::ELEM_W-1:0]  s_vec_value,
    input  logic signed [gsmv_pkg::ELEM_W-1:0]  s_weight_value,
    input  logic        [gsmv_pkg::SCALE_W-1:0] s_vec_scale,
    input  logic        [gsmv_pkg::SCALE_W-1:0] s_weight_scale,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [gsmv_pkg::ROW_W-1:0]   m_row_value,
    output logic                                m_matrix_last
);
    import gsmv_pkg::*;

    localparam int LOG_N   = (MAX_GROUP_SIZE > 1) ? $clog2(MAX_GROUP_SIZE) : 0;
    localparam int GSUM_W  = 2 * ELEM_W + LOG_N;
    localparam int A_W     = GSUM_W - 1;
    localparam int P_W     = 2 * SCALE_W;
    localparam int MAG_W   = A_W + P_W;
    localparam int SH      = 2 * SCALE_FRACTION_BITS - 24;
    localparam int SHIFT_R = (SH > 0) ? SH : 0;
    localparam int SHIFT_L = (SH < 0) ? -SH : 0;
    localparam int EXT_W   = MAG_W + SHIFT_L;
    localparam int TERM_W  = ROW_W + 1;
    localparam int SUM_W   = ROW_W + 3;

    localparam logic [MAG_W-1:0]  REM_MASK = ~({MAG_W{1'b1}} << SHIFT_R);
    localparam logic [EXT_W:0]    CAP_EXT  = (EXT_W + 1)'(1) << ROW_W;
    localparam logic [TERM_W-1:0] CAP      = TERM_W'(1) << ROW_W;
    localparam logic signed [SUM_W-1:0] ROW_MAX_S = SUM_W'({1'b0, {(ROW_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] ROW_MIN_S = -ROW_MAX_S - SUM_W'(1);

    logic signed [GSUM_W-1:0] group_sum_reg;
    logic signed [2*ELEM_W-1:0] prod;
    logic signed [GSUM_W-1:0] sum_next;

    logic                 neg_reg;
    logic [A_W-1:0]       amag_reg;
    logic [SCALE_W-1:0]   ws_reg, vs_reg;
    logic [P_W-1:0]       p_reg;
    logic [A_W+SCALE_W-1:0] lp_reg, hp_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [TERM_W-1:0]    term_reg;

    logic [EXT_W-1:0]     shr;
    logic [EXT_W:0]       inc;
    logic                 rem;

    logic signed [ROW_W-1:0] row_sum_reg;
    logic signed [SUM_W-1:0] row_add;
    logic signed [ROW_W-1:0] row_sat;

    logic                    m_valid_reg;
    logic signed [ROW_W-1:0] m_row_value_reg;
    logic                    m_last_reg;

    assign prod     = s_vec_value * s_weight_value;
    assign sum_next = group_sum_reg + GSUM_W'(prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_sum_reg <= '0;
        end else if (cmd.accept) begin
            group_sum_reg <= cmd.grp_end ? '0 : sum_next;
        end
    end

    // Group end: sign and magnitude of the closed sum, scales of that item.
    always_ff @(posedge aclk) begin
        if (cmd.accept && cmd.grp_end) begin
            neg_reg  <= sum_next[GSUM_W-1];
            amag_reg <= sum_next[GSUM_W-1] ? A_W'(-sum_next) : A_W'(sum_next);
            ws_reg   <= s_weight_scale;
            vs_reg   <= s_vec_scale;
        end
    end

    // Scale pipeline. The holding registers stay put while it runs, so the
    // stages simply recompute every cycle and settle one after another.
    always_ff @(posedge aclk) begin
        p_reg    <= ws_reg * vs_reg;
        lp_reg   <= amag_reg * p_reg[SCALE_W-1:0];
        hp_reg   <= amag_reg * p_reg[P_W-1:SCALE_W];
        mag_reg  <= MAG_W'(lp_reg) + (MAG_W'(hp_reg) << SCALE_W);
        term_reg <= (inc > CAP_EXT) ? CAP : inc[TERM_W-1:0];
    end

    // Move to 24 fraction bits; a negative term rounds toward minus infinity,
    // which on the magnitude is a round up when bits are shifted out.
    always_comb begin
        shr = (EXT_W'(mag_reg) << SHIFT_L) >> SHIFT_R;
        rem = |(mag_reg & REM_MASK);
        inc = {1'b0, shr} + (EXT_W + 1)'(neg_reg && rem);
    end

    always_comb begin
        if (neg_reg) begin
            row_add = SUM_W'(row_sum_reg) - SUM_W'(term_reg);
        end else begin
            row_add = SUM_W'(row_sum_reg) + SUM_W'(term_reg);
        end
        if (row_add > ROW_MAX_S) begin
            row_sat = ROW_MAX_S[ROW_W-1:0];
        end else if (row_add < ROW_MIN_S) begin
            row_sat = ROW_MIN_S[ROW_W-1:0];
        end else begin
            row_sat = row_add[ROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_sum_reg <= '0;
        end else if (cmd.commit) begin
            row_sum_reg <= cmd.row_end ? '0 : row_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit && cmd.row_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && cmd.row_end) begin
            m_row_value_reg <= row_sat;
            m_last_reg      <= cmd.last;
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_row_value   = m_row_value_reg;
    assign m_matrix_last = m_last_reg;

endmodule

[src/group_scaled_int8_matvec.sv]
// ----------------------------------------------------------------------------
// group_scaled_int8_matvec: group quantized int8 matrix-vector multiply
// Streams int8 vector/weight pairs, scales each group sum by its two Q4.28
// scales and emits one saturated Q23.24 dot product per matrix row.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Moves
//  -------   -------------------------------------   -------------------------
//  input     s_valid/s_ready, s_vec_value,           one element pair and the
//            s_weight_value, s_vec_scale,            group scales per item
//            s_weight_scale
//  output    m_valid/m_ready, m_row_value,           one row result per item
//            m_matrix_last
//  config    cfg_we, cfg_index, cfg_data             one register per write
//
//  An item inside a group is the multiply-accumulate of the element pair into
//  the group sum. The item that closes a group also holds off input while it
//  passes the scale pipeline (scale product, two partial products on its
//  32-bit halves, their sum, the shift and clamp) and the row sum update.
//  Reset (aresetn low, synchronous) restores the register defaults and
//  clears all counters and sums; no clearing pass is needed.
//  A row result waits in the output register while m_ready is low, and items
//  keep being accepted meanwhile; only a row end that finds the register still
//  full waits until the earlier row is taken.
//
module group_scaled_int8_matvec #(
    parameter int MAX_GROUP_SIZE      = gsmv_pkg::MAX_GROUP_SIZE_DEF,
    parameter int SCALE_FRACTION_BITS = gsmv_pkg::SCALE_FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [gsmv_pkg::ELEM_W-1:0]  s_vec_value,
    input  logic signed [gsmv_pkg::ELEM_W-1:0]  s_weight_value,
    input  logic        [gsmv_pkg::SCALE_W-1:0] s_vec_scale,
    input  logic        [gsmv_pkg::SCALE_W-1:0] s_weight_scale,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [gsmv_pkg::ROW_W-1:0]   m_row_value,
    output logic                                m_matrix_last,
    input  logic                                cfg_we,
    input  logic [gsmv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsmv_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gsmv_pkg::*;

    // The controller owns the configuration and all counters; the datapath
    // owns every sum and the output register. They talk only through these.
    gsmv_cmd_t  cmd;
    gsmv_stat_t stat;

    gsmv_ctrl #(
        .MAX_GROUP_SIZE (MAX_GROUP_SIZE)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath also carries the scale pipeline, whose depth the
    // controller covers with its wait count.
    gsmv_datapath #(
        .MAX_GROUP_SIZE      (MAX_GROUP_SIZE),
        .SCALE_FRACTION_BITS (SCALE_FRACTION_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_vec_value    (s_vec_value),
        .s_weight_value (s_weight_value),
        .s_vec_scale    (s_vec_scale),
        .s_weight_scale (s_weight_scale),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_value    (m_row_value),
        .m_matrix_last  (m_matrix_last)
    );

endmodule

[src/gsmv_checker.sv]
// ----------------------------------------------------------------------------
// gsmv_checker: port level checks for the group scaled int8 matvec block
// Watches the top level ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module gsmv_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic signed [gsmv_pkg::ELEM_W-1:0]  s_vec_value,
    input logic signed [gsmv_pkg::ELEM_W-1:0]  s_weight_value,
    input logic        [gsmv_pkg::SCALE_W-1:0] s_vec_scale,
    input logic        [gsmv_pkg::SCALE_W-1:0] s_weight_scale,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [gsmv_pkg::ROW_W-1:0]   m_row_value,
    input logic                                m_matrix_last
);
    import gsmv_pkg::*;

    // A stalled row result keeps its value and flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_value) && $stable(m_matrix_last))
        else $error("row result changed while stalled");

    // A stalled input item keeps its element pair and scales.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_vec_value) && $stable(s_weight_value)
            && $stable(s_vec_scale) && $stable(s_weight_scale))
        else $error("input item changed while stalled");

    // No row result is pending right after reset.
    assert property (@(posedge aclk) $rose(aresetn) |-> !m_valid)
        else $error("row result valid after reset");

    // A row result only appears while the scale pipeline holds off input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("row result appeared outside a group end");

    // A group end blocks input for at least the depth of the scale pipeline.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> !s_ready ##1 !s_ready ##1 !s_ready ##1 !s_ready ##1 !s_ready)
        else $error("input accepted while the scale pipeline was busy");

endmodule

bind group_scaled_int8_matvec gsmv_checker u_gsmv_checker (.*);

[test/tb_group_scaled_int8_matvec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_group_scaled_int8_matvec: self-checking bench for the group scaled matvec
// Streams int8 element pairs with Q4.28 scales into the block. An in-bench
// predictor computes each row dot product, and every row result is checked in
// order. The row geometry changes between bursts, and both handshakes idle at
// random.
// ----------------------------------------------------------------------------
module tb_group_scaled_int8_matvec;

    import gsmv_pkg::*;

    // Bench timing and pacing.
    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 3;
    localparam int IDLE_PERCENT   = 36;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    // A group end passes the scale pipeline and the row sum update; leave
    // margin for that before the geometry registers are touched or the run is closed.
    localparam int SETTLE_CYCLES  = SCALE_CYCLES + 10;

    // Fixed-point constants of the predictor. The product of a group sum and
    // two scales carries 2F fraction bits; rows keep 24 of them.
    localparam int FRAC_SHIFT = 2 * SCALE_FRACTION_BITS_DEF - 24;
    localparam logic [SCALE_W-1:0] ONE_Q28 = 32'h1000_0000;
    localparam logic signed [127:0] TERM_LIMIT = 128'sd1 <<< 48;
    localparam longint ROW_MAX = (64'sd1 <<< (ROW_W - 1)) - 1;
    localparam longint ROW_MIN = -ROW_MAX - 1;

    typedef struct {
        logic signed [ROW_W-1:0] row_value;
        logic                    matrix_last;
    } row_result_t;

    // Clock, reset and block ports.
    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [ELEM_W-1:0] s_vec_value;
    logic signed [ELEM_W-1:0] s_weight_value;
    logic [SCALE_W-1:0] s_vec_scale;
    logic [SCALE_W-1:0] s_weight_scale;
    logic m_valid;
    logic m_ready;
    logic signed [ROW_W-1:0] m_row_value;
    logic m_matrix_last;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Pacing controls shared by the sender, the result sink and the tests.
    bit idle_enable = 1'b1;
    bit hold_output = 1'b0;

    // Row results still owed by the block, oldest first.
    row_result_t expected_rows[$];
    int error_count = 0;
    int quiet_cycles = 0;

    // Predictor copy of the geometry registers, at their reset values.
    logic [GS_CFG_W-1:0]  geo_group_size     = GS_RESET;
    logic [GPR_CFG_W-1:0] geo_groups_per_row = GPR_RESET;
    logic [RC_CFG_W-1:0]  geo_row_count      = RC_RESET;

    // Predictor copy of the accumulation state, cleared by the one reset.
    int          group_acc   = 0;
    int unsigned elem_count  = 0;
    int unsigned group_count = 0;
    int unsigned row_pos     = 0;
    longint      row_acc     = 0;

    group_scaled_int8_matvec dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_vec_value    (s_vec_value),
        .s_weight_value (s_weight_value),
        .s_vec_scale    (s_vec_scale),
        .s_weight_scale (s_weight_scale),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_value    (m_row_value),
        .m_matrix_last  (m_matrix_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // A register value of zero behaves as one, and anything above the
    // hardware limit behaves as the limit.
    function automatic int unsigned effective_size(input int unsigned raw,
                                                   input int unsigned ceiling);
        if (raw == 0) return 1;
        return (raw > ceiling) ? ceiling : raw;
    endfunction

    // Group sum times both scales, floored down to 24 fraction bits and
    // clamped to a magnitude of 2^48. The 128-bit product is exact.
    function automatic longint scaled_group_term(input int gsum,
                                                 input logic [SCALE_W-1:0] wscale,
                                                 input logic [SCALE_W-1:0] vscale);
        logic signed [127:0] wide_sum;
        logic signed [127:0] wide_w;
        logic signed [127:0] wide_v;
        logic signed [127:0] product;
        wide_sum = gsum;
        wide_w   = {96'd0, wscale};
        wide_v   = {96'd0, vscale};
        product  = (wide_sum * wide_w * wide_v) >>> FRAC_SHIFT;
        if (product > TERM_LIMIT) product = TERM_LIMIT;
        else if (product < -TERM_LIMIT) product = -TERM_LIMIT;
        return longint'(product);
    endfunction

    // Advances the predicted state by one accepted item and queues the row
    // result when the item closes a row. Boundaries use "reached or passed",
    // so a geometry that shrank under a half-built row closes it at once.
    function automatic void accumulate_pair(input logic signed [ELEM_W-1:0] vec,
                                            input logic signed [ELEM_W-1:0] wgt,
                                            input logic [SCALE_W-1:0] vscale,
                                            input logic [SCALE_W-1:0] wscale);
        int unsigned gs;
        int unsigned gpr;
        int unsigned rc;
        longint row_next;
        row_result_t row;
        gs  = effective_size(geo_group_size, MAX_GROUP_SIZE_DEF);
        gpr = effective_size(geo_groups_per_row, GPR_MAX);
        rc  = effective_size(geo_row_count, RC_MAX);

        group_acc += vec * wgt;
        if (elem_count + 1 < gs) begin
            elem_count++;
            return;
        end

        // Group end: the scales of this item apply to the whole group.
        row_next = row_acc + scaled_group_term(group_acc, wscale, vscale);
        if (row_next > ROW_MAX) row_next = ROW_MAX;
        if (row_next < ROW_MIN) row_next = ROW_MIN;
        row_acc    = row_next;
        group_acc  = 0;
        elem_count = 0;
        if (group_count + 1 < gpr) begin
            group_count++;
            return;
        end

        // Row end: emit, then wrap the row position after the last row.
        row.row_value   = row_acc[ROW_W-1:0];
        row.matrix_last = (row_pos + 1 >= rc);
        expected_rows.push_back(row);
        row_acc     = 0;
        group_count = 0;
        row_pos     = row.matrix_last ? 0 : row_pos + 1;
    endfunction

    // ------------------------------------------------------------------------
    // Item driver and configuration
    // ------------------------------------------------------------------------

    // Offers one item from a falling edge and returns at the rising edge that
    // accepts it. The next call or drain_rows decides what valid does next, so
    // valid is assigned only once per time step and stays high back to back.
    task automatic send_pair(input logic signed [ELEM_W-1:0] vec,
                             input logic signed [ELEM_W-1:0] wgt,
                             input logic [SCALE_W-1:0] vscale,
                             input logic [SCALE_W-1:0] wscale);
        @(negedge aclk);
        while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_vec_value    <= vec;
        s_weight_value <= wgt;
        s_vec_scale    <= vscale;
        s_weight_scale <= wscale;
        do @(posedge aclk); while (!s_ready);
        accumulate_pair(vec, wgt, vscale, wscale);
    endtask

    // Element values lean on the two extremes; scales mix full-range values,
    // values near 1.0, small values and both ends of the range.
    function automatic logic signed [ELEM_W-1:0] random_elem();
        case ($urandom_range(7))
            0: return 8'sh80;
            1: return 8'sh7F;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] random_scale();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            4, 5: return ONE_Q28 ^ SCALE_W'($urandom_range(0, 16'hFFFF));
            default: return SCALE_W'($urandom_range(0, 20'hF_FFFF));
        endcase
    endfunction

    task automatic send_random_pair();
        send_pair(random_elem(), random_elem(), random_scale(), random_scale());
    endtask

    // Stops offering items, waits for every owed row, then lets the scale
    // pipeline finish any group end that produces no row.
    task automatic drain_rows();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_rows.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes all three geometry registers on consecutive cycles, only once
    // the block has gone idle.
    task automatic set_geometry(input logic [GS_CFG_W-1:0] gs,
                                input logic [GPR_CFG_W-1:0] gpr,
                                input logic [RC_CFG_W-1:0] rc);
        drain_rows();
        geo_group_size     = gs;
        geo_groups_per_row = gpr;
        geo_row_count      = rc;
        cfg_we    <= 1'b1;
        cfg_index <= REG_GROUP_SIZE;
        cfg_data  <= CFG_DATA_W'(gs);
        @(negedge aclk);
        cfg_index <= REG_GROUPS_PER_ROW;
        cfg_data  <= CFG_DATA_W'(gpr);
        @(negedge aclk);
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= CFG_DATA_W'(rc);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Starts under the reset geometry (32 per group, 8 groups, 288 rows), so
    // the register defaults decide where the first group closes. The row is
    // then cut short by shrinking the geometry while the counters stand past
    // the new sizes, once for the group counter and once for the element one.
    task automatic test_geometry_change();
        repeat (40) send_random_pair();
        set_geometry(9'd1, 13'd3, 17'd2);
        repeat (6) send_random_pair();
        // Oversized values clamp; twelve groups leave the row well open.
        set_geometry(9'd1, 13'd8191, 17'd131071);
        repeat (12) send_random_pair();
        set_geometry(9'd1, 13'd3, 17'd2);
        repeat (4) send_random_pair();
        set_geometry(9'd511, 13'd1, 17'd65536);
        repeat (10) send_random_pair();
        set_geometry(9'd4, 13'd2, 17'd1);
        repeat (8) send_random_pair();
    endtask

    // Zero in every register acts as one: each item is a whole matrix.
    task automatic test_zero_geometry();
        set_geometry('0, '0, '0);
        send_pair(8'sh7F, 8'sh7F, '1, '1);
        send_pair(8'sh80, 8'sh7F, ONE_Q28, ONE_Q28);
        send_pair(8'sh00, 8'shFF, '0, '0);
    endtask

    // One element per group, two groups per row, two rows per matrix, so
    // matrix_last alternates and the row position wraps. Covers the element
    // extremes, zero and full scales, and the floor of a tiny negative term.
    task automatic test_element_extremes();
        set_geometry(9'd1, 13'd2, 17'd2);
        send_pair(8'sh80, 8'sh80, '1, '1);
        send_pair(8'sh7F, 8'sh7F, '1, '0);
        send_pair(8'sh80, 8'sh7F, 32'd1, 32'd1);
        send_pair(8'sh7F, 8'sh80, ONE_Q28, ONE_Q28);
        send_pair(8'shFF, 8'sh01, 32'd1, 32'd1);
        send_pair(8'sh01, 8'sh01, 32'd1, 32'd1);
        send_pair(8'sh00, 8'sh00, '1, '1);
        send_pair(8'sh80, 8'sh80, ONE_Q28, ONE_Q28);
    endtask

    // Eight maximal products under full scales push the term past 2^48 so it
    // clamps, and the one-group row then clamps at the 48-bit limits, first
    // positive and then negative.
    task automatic test_term_overflow();
        set_geometry(9'd8, 13'd1, 17'd1);
        repeat (8) send_pair(8'sh80, 8'sh80, '1, '1);
        repeat (8) send_pair(8'sh7F, 8'sh80, '1, '1);
    endtask

    // The largest group, reached through a clamped register value, filled
    // with the largest product so the group sum hits its widest value.
    task automatic test_full_group();
        set_geometry(9'd511, 13'd1, 17'd1);
        repeat (MAX_GROUP_SIZE_DEF) send_pair(8'sh80, 8'sh80, ONE_Q28, ONE_Q28);
    endtask

    // Every item is a row. The sink holds m_ready low for a long stretch while
    // the sender keeps offering, so the output register fills and the block
    // has to stall its input.
    task automatic test_output_backpressure();
        set_geometry(9'd1, 13'd1, 17'd3);
        idle_enable = 1'b0;
        hold_output = 1'b1;
        repeat (30) send_random_pair();
        idle_enable = 1'b1;
    endtask

    // Bursts of random items under random geometries. Most geometries are
    // small so rows close often; the rest are zero, the limits, oversized or
    // mid-sized values, whose half-built rows the next burst then cuts short.
    task automatic test_random_geometries(input int pair_budget, input bit with_idles);
        int sent;
        int burst;
        logic [GS_CFG_W-1:0]  gs;
        logic [GPR_CFG_W-1:0] gpr;
        logic [RC_CFG_W-1:0]  rc;
        sent = 0;
        idle_enable = with_idles;
        while (sent < pair_budget) begin
            case ($urandom_range(9))
                0: gs = '0;
                1: gs = GS_CFG_W'($urandom_range(257, 511));
                2: gs = GS_CFG_W'($urandom_range(7, 40));
                default: gs = GS_CFG_W'($urandom_range(1, 6));
            endcase
            case ($urandom_range(9))
                0: gpr = '0;
                1: gpr = GPR_MAX;
                2: gpr = GPR_CFG_W'($urandom_range(4097, 8191));
                default: gpr = GPR_CFG_W'($urandom_range(1, 4));
            endcase
            case ($urandom_range(9))
                0: rc = '0;
                1: rc = RC_MAX;
                2: rc = RC_CFG_W'($urandom_range(65537, 131071));
                default: rc = RC_CFG_W'($urandom_range(1, 4));
            endcase
            set_geometry(gs, gpr, rc);
            burst = $urandom_range(15, 60);
            repeat (burst) send_random_pair();
            sent += burst;
        end
        idle_enable = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Result sink, checker and watchdog
    // ------------------------------------------------------------------------

    // Drives m_ready at falling edges. A hold request keeps it low for a
    // stretch timed here before random idling resumes.
    initial begin : result_sink
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_output) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_output = 1'b0;
            end
            m_ready <= !(idle_enable && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Each accepted row is matched against the oldest owed row.
    always @(posedge aclk) begin : check_rows
        row_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rows.size() == 0) begin
                error_count++;
                $display("%0t: row result with none owed: expected none, got %0d last %0b",
                         $time, m_row_value, m_matrix_last);
            end else begin
                want = expected_rows.pop_front();
                if (m_row_value !== want.row_value) begin
                    error_count++;
                    $display("%0t: row_value mismatch: expected %0d, got %0d",
                             $time, want.row_value, m_row_value);
                end
                if (m_matrix_last !== want.matrix_last) begin
                    error_count++;
                    $display("%0t: matrix_last mismatch: expected %0b, got %0b",
                             $time, want.matrix_last, m_matrix_last);
                end
            end
        end
    end

    // Ends the run when neither channel has moved an item for too long.
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_vec_value    = '0;
        s_weight_value = '0;
        s_vec_scale    = '0;
        s_weight_scale = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_GROUP_SIZE;
        cfg_data       = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_geometry_change();
        test_zero_geometry();
        test_element_extremes();
        test_term_overflow();
        test_full_group();
        test_output_backpressure();
        // A stretch with no idling on either side, then the idling mix.
        test_random_geometries(150, 1'b0);
        test_random_geometries(310, 1'b1);

        drain_rows();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
